@@ sv/wvp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wvp_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic REQ_PROJECT = 1'b0;
  localparam logic REQ_WRITE   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO_W = 2'd1,
    ST_OVF    = 2'd2
  } status_e;

  typedef struct packed {
    logic               req_type;
    logic [4:0]         matrix_index;
    logic signed [31:0] matrix_value;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
    logic signed [31:0] ndc_depth;
    logic               ahead;
    logic               inside_view;
  } out_item_t;

  // Side information that rides along with the three quotient lanes
  typedef struct packed {
    logic       valid;
    status_e    status;
    logic [2:0] neg;
    logic       front;
  } div_tag_t;

endpackage

`default_nettype wire

@@ sv/world_to_viewport_projection.sv @@
`timescale 1ns / 1ps
`default_nettype none

// World point to viewport pixel projection, signed fixed point.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries two kinds of beat:
// a matrix element write (view 0-15, projection 16-31, column-major) that gives
// no result, or a world point that gives exactly one result beat on the output
// channel (out_valid_o / out_stall_i / out_data_o) with pixel x/y, ndc depth,
// front/inside flags and a status. Writes and points keep stream order.
// Throughput is one beat per cycle while the receiver does not stall. The
// perspective divide uses a two-bit-per-stage divider. The cfg port sets the
// viewport size; write it only while no point is in flight. Reset empties the
// pipeline and sets the viewport to 1 x 1; matrix elements hold nothing until
// written. When the receiver stalls with a result waiting, the whole pipeline
// holds and in_stall_o rises in the same cycle; nothing is lost or repeated.
module world_to_viewport_projection #(
  parameter int FRAC_BITS = wvp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wvp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wvp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  wvp_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output wvp_pkg::out_item_t               out_data_o
);
  import wvp_pkg::*;

  localparam int DIV_STAGES = (32 + FRAC_BITS + 1) / 2;
  localparam int QW         = 2 * DIV_STAGES;
  localparam logic signed [32:0] ONE  = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [48:0] HALF = 49'sd1 <<< (FRAC_BITS - 1);

  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic                  adv;

  logic signed [31:0] view_q [16];
  logic signed [31:0] proj_q [16];

  // stage 1: input register
  logic     s1_vld_q;
  in_item_t s1_q;
  // stage A: view products
  logic               a_vld_q, a_wr_q;
  logic [4:0]         a_idx_q;
  logic signed [31:0] a_val_q;
  logic signed [63:0] pv_q [16];
  logic signed [63:0] pv_d [16];
  // stage B: eye vector
  logic               b_vld_q, b_wr_q, b_ovf_q;
  logic [4:0]         b_idx_q;
  logic signed [31:0] b_val_q;
  logic signed [31:0] eye_q [4];
  logic signed [31:0] eye_d [4];
  logic               eye_ovf;
  // stage C: projection products
  logic               c_vld_q, c_ovf_q;
  logic signed [63:0] pc_q [16];
  logic signed [63:0] pc_d [16];
  // stage D: clip vector
  logic               d_vld_q, d_ovf_q;
  logic signed [31:0] clip_q [4];
  logic signed [31:0] clip_d [4];
  logic               clip_ovf;
  // divider
  div_tag_t    dv_tag_in, dv_tag_out;
  logic [31:0] dv_num [3];
  logic [31:0] dv_den;
  logic [QW-1:0] dv_quo [3];
  // stage E: ndc
  logic               e_vld_q, e_front_q;
  status_e            e_status_q, e_status_d;
  logic signed [31:0] ndc_q [3];
  logic signed [31:0] ndc_d [3];
  // stage F: viewport products
  logic               f_vld_q, f_front_q, f_inside_q;
  status_e            f_status_q;
  logic signed [31:0] f_z_q;
  logic signed [48:0] mx_q, my_q, mx_d, my_d;
  logic               inside_d;
  // output register
  logic      out_valid_q;
  out_item_t out_q, out_d;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DATA_W'(1);
      height_q <= CFG_DATA_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      d_vld_q     <= 1'b0;
      e_vld_q     <= 1'b0;
      f_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q    <= in_valid_i;
      a_vld_q     <= s1_vld_q;
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q && !b_wr_q;
      d_vld_q     <= c_vld_q;
      e_vld_q     <= dv_tag_out.valid;
      f_vld_q     <= e_vld_q;
      out_valid_q <= f_vld_q;
    end
  end

  // Each matrix is written where its products are formed, so beats stay in order
  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q && s1_q.req_type == REQ_WRITE && !s1_q.matrix_index[4]) begin
      view_q[s1_q.matrix_index[3:0]] <= s1_q.matrix_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && b_vld_q && b_wr_q && b_idx_q[4]) begin
      proj_q[b_idx_q[3:0]] <= b_val_q;
    end
  end

  always_comb begin
    logic signed [31:0] pt [3];
    pt[0] = s1_q.world_x;
    pt[1] = s1_q.world_y;
    pt[2] = s1_q.world_z;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        pv_d[c*4+r] = (view_q[c*4+r] * pt[c]) >>> FRAC_BITS;
      end
      pv_d[12+r] = 64'(view_q[12+r]);
    end
  end

  always_comb begin
    logic signed [65:0] sum;
    eye_ovf = 1'b0;
    for (int r = 0; r < 4; r++) begin
      sum = 66'(pv_q[r]) + 66'(pv_q[4+r]) + 66'(pv_q[8+r]) + 66'(pv_q[12+r]);
      eye_d[r] = sum[31:0];
      if (sum[65:31] != {35{sum[31]}}) eye_ovf = 1'b1;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        pc_d[c*4+r] = (proj_q[c*4+r] * eye_q[c]) >>> FRAC_BITS;
      end
    end
  end

  always_comb begin
    logic signed [65:0] sum;
    clip_ovf = 1'b0;
    for (int r = 0; r < 4; r++) begin
      sum = 66'(pc_q[r]) + 66'(pc_q[4+r]) + 66'(pc_q[8+r]) + 66'(pc_q[12+r]);
      clip_d[r] = sum[31:0];
      if (sum[65:31] != {35{sum[31]}}) clip_ovf = 1'b1;
    end
  end

  // Divider feed: magnitudes in, signs on the side
  always_comb begin
    dv_tag_in.valid = d_vld_q;
    if (d_ovf_q) begin
      dv_tag_in.status = ST_OVF;
    end else if (clip_q[3] == '0) begin
      dv_tag_in.status = ST_ZERO_W;
    end else begin
      dv_tag_in.status = ST_OK;
    end
    dv_tag_in.front = !clip_q[3][31] && (clip_q[3] != '0);
    for (int l = 0; l < 3; l++) begin
      dv_tag_in.neg[l] = clip_q[l][31] ^ clip_q[3][31];
      dv_num[l]        = clip_q[l][31] ? 32'(-clip_q[l]) : 32'(clip_q[l]);
    end
    dv_den = clip_q[3][31] ? 32'(-clip_q[3]) : 32'(clip_q[3]);
  end

  wvp_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (dv_tag_in),
    .num_i  (dv_num),
    .den_i  (dv_den),
    .tag_o  (dv_tag_out),
    .quo_o  (dv_quo)
  );

  always_comb begin
    logic over;
    over = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if ((|dv_quo[l][QW-1:32]) ||
          (dv_quo[l][31] && (!dv_tag_out.neg[l] || (|dv_quo[l][30:0])))) begin
        over = 1'b1;
      end
      ndc_d[l] = dv_tag_out.neg[l] ? -dv_quo[l][31:0] : dv_quo[l][31:0];
    end
    if (dv_tag_out.status != ST_OK) begin
      e_status_d = dv_tag_out.status;
    end else if (over) begin
      e_status_d = ST_OVF;
    end else begin
      e_status_d = ST_OK;
    end
  end

  always_comb begin
    logic signed [32:0] xs, ys;
    xs   = 33'(ndc_q[0]) + ONE;
    ys   = ONE - 33'(ndc_q[1]);
    mx_d = xs * $signed({1'b0, width_q});
    my_d = ys * $signed({1'b0, height_q});
    inside_d = e_front_q;
    for (int l = 0; l < 3; l++) begin
      if (33'(ndc_q[l]) < -ONE || 33'(ndc_q[l]) > ONE) inside_d = 1'b0;
    end
  end

  always_comb begin
    logic signed [48:0] px, py;
    status_e            st;
    px = (mx_q >>> 1) - HALF;
    py = (my_q >>> 1) - HALF;
    st = f_status_q;
    if (width_q == '0 || height_q == '0) begin
      st = ST_OVF;
    end else if (st == ST_OK &&
                 (px[48:31] != {18{px[31]}} || py[48:31] != {18{py[31]}})) begin
      st = ST_OVF;
    end
    out_d = '0;
    out_d.status = st;
    if (st == ST_OK) begin
      out_d.pixel_x     = px[31:0];
      out_d.pixel_y     = py[31:0];
      out_d.ndc_depth   = f_z_q;
      out_d.ahead       = f_front_q;
      out_d.inside_view = f_inside_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q       <= in_data_i;
      a_wr_q     <= s1_q.req_type == REQ_WRITE;
      a_idx_q    <= s1_q.matrix_index;
      a_val_q    <= s1_q.matrix_value;
      pv_q       <= pv_d;
      b_wr_q     <= a_wr_q;
      b_idx_q    <= a_idx_q;
      b_val_q    <= a_val_q;
      b_ovf_q    <= eye_ovf;
      eye_q      <= eye_d;
      c_ovf_q    <= b_ovf_q;
      pc_q       <= pc_d;
      d_ovf_q    <= c_ovf_q || clip_ovf;
      clip_q     <= clip_d;
      e_status_q <= e_status_d;
      e_front_q  <= dv_tag_out.front;
      ndc_q      <= ndc_d;
      f_status_q <= e_status_q;
      f_front_q  <= e_front_q;
      f_inside_q <= inside_d;
      f_z_q      <= ndc_q[2];
      mx_q       <= mx_d;
      my_q       <= my_d;
      out_q      <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ sv/wvp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wvp_div #(
  parameter int FRAC_BITS = wvp_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  wvp_pkg::div_tag_t tag_i,
  input  logic [31:0]       num_i [3],
  input  logic [31:0]       den_i,
  output wvp_pkg::div_tag_t tag_o,
  output logic [2*((32+FRAC_BITS+1)/2)-1:0] quo_o [3]
);
  import wvp_pkg::*;

  localparam int STAGES = (32 + FRAC_BITS + 1) / 2;
  localparam int NP     = 2 * STAGES;

  // nq holds the unused numerator bits on top and the quotient bits below
  logic [NP-1:0] nq_q  [STAGES][3];
  logic [31:0]   rem_q [STAGES][3];
  logic [31:0]   den_q [STAGES];
  div_tag_t      tag_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [NP-1:0] nq_in  [3];
    logic [31:0]   rem_in [3];
    logic [31:0]   den_in;
    div_tag_t      tag_in;
    logic [NP-1:0] nq_d   [3];
    logic [31:0]   rem_d  [3];

    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          nq_in[l]  = NP'({num_i[l], {FRAC_BITS{1'b0}}});
          rem_in[l] = '0;
        end
        den_in = den_i;
        tag_in = tag_i;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          nq_in[l]  = nq_q[s-1][l];
          rem_in[l] = rem_q[s-1][l];
        end
        den_in = den_q[s-1];
        tag_in = tag_q[s-1];
      end
    end

    // Two restoring steps per stage
    always_comb begin
      logic [32:0]   t;
      logic [31:0]   r;
      logic [NP-1:0] nq;
      for (int l = 0; l < 3; l++) begin
        r  = rem_in[l];
        nq = nq_in[l];
        for (int k = 0; k < 2; k++) begin
          t  = {r, nq[NP-1]};
          nq = {nq[NP-2:0], 1'b0};
          if (t >= {1'b0, den_in}) begin
            t     = t - {1'b0, den_in};
            nq[0] = 1'b1;
          end
          r = t[31:0];
        end
        nq_d[l]  = nq;
        rem_d[l] = r;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (en_i) begin
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 3; l++) begin
          nq_q[s][l]  <= nq_d[l];
          rem_q[s][l] <= rem_d[l];
        end
        den_q[s] <= den_in;
      end
    end
  end

  assign tag_o = tag_q[STAGES-1];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quo_o[l] = nq_q[STAGES-1][l];
    end
  end

endmodule

`default_nettype wire
